/* rtl/scsa_pkg.sv */
// Shared types and constants for the size-class slab allocator.
package scsa_pkg;

  localparam int ADDR_W  = 20;
  localparam int SIZE_W  = 16;
  localparam int CLS_W   = 4;
  localparam int CNT_W   = 18;
  localparam int STAT_W  = 3;
  localparam int NCLS    = 13;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_PAGES  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_HANDL = 3'd4;
  localparam logic [STAT_W-1:0] ST_BAD_PAGE  = 3'd5;

  localparam logic [CNT_W-1:0] COUNT_MAX = 18'h3FFFF;

  // classified request handed from front to back
  typedef struct packed {
    logic              is_free;
    logic              early;    // result fully known at classify time
    logic [STAT_W-1:0] status;
    logic [CLS_W-1:0]  cls;
    logic [ADDR_W-1:0] addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] entry_address;
    logic [STAT_W-1:0] status;
    logic [CLS_W-1:0]  class_index;
    logic [CNT_W-1:0]  class_objects;
  } res_t;

  function automatic logic [11:0] class_bytes(input logic [CLS_W-1:0] c);
    case (c)
      4'd0:  class_bytes = 12'd4;
      4'd1:  class_bytes = 12'd8;
      4'd2:  class_bytes = 12'd16;
      4'd3:  class_bytes = 12'd24;
      4'd4:  class_bytes = 12'd32;
      4'd5:  class_bytes = 12'd48;
      4'd6:  class_bytes = 12'd64;
      4'd7:  class_bytes = 12'd96;
      4'd8:  class_bytes = 12'd128;
      4'd9:  class_bytes = 12'd256;
      4'd10: class_bytes = 12'd384;
      4'd11: class_bytes = 12'd512;
      4'd12: class_bytes = 12'd1024;
      default: class_bytes = 12'd0;
    endcase
  endfunction

endpackage

/* rtl/scsa_front.sv */
// Front end: accepts requests, picks the size class, screens frees.
module scsa_front import scsa_pkg::*; #(
  parameter int PAGE_SH = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [SIZE_W-1:0] request_size,
  input  logic [ADDR_W-1:0] free_address,
  output logic              q_valid,
  input  logic              q_ready,
  output req_t              q_data
);

  // two-entry queue
  req_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  req_t       cur;
  logic [CLS_W-1:0] cls;
  logic       found;

  always_comb begin
    found = 1'b0;
    cls = '0;
    for (int i = NCLS - 1; i >= 0; i--) begin
      if ({4'd0, class_bytes(CLS_W'(i))} >= request_size) begin
        found = 1'b1;
        cls = CLS_W'(i);
      end
    end
    cur = '0;
    cur.is_free = command;
    cur.addr = free_address;
    if (!command) begin
      cur.early = !found;
      cur.status = found ? ST_OK : ST_TOO_LARGE;
      cur.cls = cls;
    end else if (free_address == '0) begin
      cur.early = 1'b1;
      cur.status = ST_NULL;
    end else if (free_address[PAGE_SH-1:0] == '0) begin
      cur.early = 1'b1;
      cur.status = ST_NOT_HANDL;
    end
  end

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_data   = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= cur;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (q_valid && q_ready) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !(q_valid && q_ready)) |=> cnt == 2'd2)
    else $error("full queue lost an entry");
  assert property (@(posedge clk) disable iff (rst) (cnt == 2'd0) |-> !q_valid)
    else $error("empty queue shows valid");

endmodule

/* rtl/scsa_back.sv */
// Back end: class state, link and tag memories, result register.
module scsa_back import scsa_pkg::*; #(
  parameter int POOL_PAGES = 256,
  parameter int PAGE_SH    = 12,
  parameter int PAGE_W     = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [8:0]        usable_pages,
  input  logic              q_valid,
  output logic              q_ready,
  input  req_t              q_data,
  output logic              out_valid,
  input  logic              out_ready,
  output res_t              out_data
);

  localparam int LINK_D = 1 << (ADDR_W - 2);
  localparam int PAGE_BYTES = 1 << PAGE_SH;

  logic [ADDR_W-1:0] head   [NCLS];
  logic [ADDR_W-1:0] cursor [NCLS];
  logic [CNT_W-1:0]  live   [NCLS];
  logic [PAGE_W-1:0] fresh;

  logic [ADDR_W-1:0] link_mem [LINK_D];
  logic [CLS_W-1:0]  tag_mem  [POOL_PAGES];
  logic [ADDR_W-1:0] link_rd;
  logic [CLS_W-1:0]  tag_rd;

  // phase 0: read memories; phase 1: update state and post result
  logic              busy;
  req_t              r;
  logic              tag_ok;

  // next request may enter while the current result is being taken
  assign q_ready = !busy && (!out_valid || out_ready);

  logic [ADDR_W-1:0] a_page_num;
  assign a_page_num = ADDR_W'(q_data.addr >> PAGE_SH);

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      link_rd <= link_mem[head[q_data.cls][ADDR_W-1:2]];
      tag_rd  <= tag_mem[q_data.addr[PAGE_SH +: PAGE_W-1]];
      r       <= q_data;
      tag_ok  <= (a_page_num < ADDR_W'(fresh)) && (a_page_num < ADDR_W'(POOL_PAGES));
    end
  end

  // link index from the head being popped
  logic [ADDR_W-1:0] h, cu, nxt, base, na, cad;
  logic [ADDR_W-1:0] limit;
  logic [11:0]       ent;
  logic [CLS_W-1:0]  fc;
  logic [CNT_W-1:0]  cnt_d;
  logic              alloc_ok;
  res_t              res_d;

  always_comb begin
    ent   = class_bytes(r.cls);
    h     = head[r.cls];
    cu    = cursor[r.cls];
    limit = (usable_pages < 9'(POOL_PAGES)) ? ADDR_W'(usable_pages) : ADDR_W'(POOL_PAGES);
    fc    = (tag_rd >= CLS_W'(NCLS)) ? '0 : tag_rd;
    if (h != '0) cad = h;
    else if (cu != '0) cad = cu;
    else cad = ADDR_W'(ADDR_W'(fresh) << PAGE_SH) + ((ent < 12'd8) ? 20'd8 : 20'(ent));
    base = {cad[ADDR_W-1:PAGE_SH], PAGE_SH'(0)};
    nxt  = cad + 20'(ent);
    na   = (21'(nxt) + 21'(ent) > 21'(base) + 21'(PAGE_BYTES)) ? '0 : nxt;
    cnt_d = live[fc];
    alloc_ok = (h != '0) || (cu != '0) || (ADDR_W'(fresh) < limit);

    res_d = '0;
    if (r.early) begin
      res_d.status = r.status;
    end else if (!r.is_free) begin
      res_d.class_index = r.cls;
      if (alloc_ok) begin
        res_d.entry_address = cad;
        res_d.class_objects = (live[r.cls] != COUNT_MAX) ? live[r.cls] + 1'b1 : live[r.cls];
      end else begin
        res_d.status = ST_NO_PAGES;
        res_d.class_objects = live[r.cls];
      end
    end else if (!tag_ok) begin
      res_d.status = ST_BAD_PAGE;
    end else begin
      res_d.class_index = fc;
      res_d.class_objects = (cnt_d != '0) ? cnt_d - 1'b1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
      fresh <= '0;
      for (int i = 0; i < NCLS; i++) begin
        head[i] <= '0;
        cursor[i] <= '0;
        live[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (q_valid && q_ready) busy <= 1'b1;
      if (busy) begin
        busy <= 1'b0;
        out_valid <= 1'b1;
        out_data <= res_d;
        if (r.early) begin
          // status only, no state change
        end else if (!r.is_free) begin
          if (h != '0) begin
            head[r.cls] <= link_rd;
          end else if (alloc_ok) begin
            if (cu == '0) begin
              fresh <= fresh + 1'b1;
              tag_mem[fresh[PAGE_W-2:0]] <= r.cls;
            end
            cursor[r.cls] <= na;
          end
          if (alloc_ok && live[r.cls] != COUNT_MAX) live[r.cls] <= live[r.cls] + 1'b1;
        end else if (tag_ok) begin
          link_mem[r.addr[ADDR_W-1:2]] <= head[fc];
          head[fc] <= r.addr;
          if (cnt_d != '0) live[fc] <= cnt_d - 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) busy |-> !out_valid)
    else $error("result posted while previous pending");
  assert property (@(posedge clk) disable iff (rst) busy |=> out_valid)
    else $error("request not completed");
  assert property (@(posedge clk) disable iff (rst) ADDR_W'(fresh) <= ADDR_W'(POOL_PAGES))
    else $error("page counter overran pool");

endmodule

/* rtl/size_class_slab_allocator.sv */
// Top level of the size-class slab allocator.
// Each request passes through the back end in phases: the first reads the link and
// tag memories (synchronous), the second updates class state and registers the
// result. The next request enters the back end in the cycle the previous
// result is taken, so the back end holds only one request at a time; a held
// result stalls the back end, and once the two-entry queue between front and
// back is full, s_tready drops.
module size_class_slab_allocator import scsa_pkg::*; #(
  parameter int POOL_PAGES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // request_size[15:0], free_address[35:16]
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // entry_address, status, class_index, class_objects
);

  localparam int PAGE_SH = 12;
  localparam int PAGE_W  = $clog2(POOL_PAGES) + 1;

  logic [8:0] usable_pages;
  logic       q_valid, q_ready;
  req_t       q_data;
  res_t       res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) usable_pages <= 9'd256;
    else if (cfg_valid) usable_pages <= cfg_data;
  end

  scsa_front #(.PAGE_SH(PAGE_SH)) u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .command(s_tuser), .request_size(s_tdata[15:0]), .free_address(s_tdata[35:16]),
    .q_valid, .q_ready, .q_data
  );

  scsa_back #(.POOL_PAGES(POOL_PAGES), .PAGE_SH(PAGE_SH), .PAGE_W(PAGE_W)) u_back (
    .clk, .rst, .usable_pages,
    .q_valid, .q_ready, .q_data,
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(res)
  );

  assign m_tdata = {3'd0, res.class_objects, res.class_index, res.status, res.entry_address};

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the size-class slab allocator.
module tb_top;
  import scsa_pkg::*;

  localparam int PAGE_SZ     = 4096;
  localparam int POOL_PG     = 256;
  localparam int HOLD_LIMIT  = 20000;
  localparam int DIRECTED_N  = 25;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [8:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // request_size[15:0], free_address[35:16]
  logic        s_tuser;   // command
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // entry_address[19:0], status[22:20], class_index[26:23],
                          // class_objects[44:27]

  size_class_slab_allocator i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // allocator shadow state
  int unsigned      entry_bytes [NCLS] = '{4, 8, 16, 24, 32, 48, 64, 96, 128, 256, 384, 512,
                                           1024};
  logic [8:0]       page_limit_reg;
  logic [19:0]      free_head [NCLS];
  logic [19:0]      cursor [NCLS];
  logic [17:0]      live_objs [NCLS];
  logic [19:0]      link_mem [bit [17:0]];
  logic [3:0]       page_tag [POOL_PG];
  int unsigned      pages_taken;

  res_t             pending_results[$];
  logic [19:0]      handed_out[$];
  int               errors;
  int               n_sent;
  int               n_checked;
  int               idle_pct;
  int               stall_pct;
  int               hold_cycles;
  int               quiet_cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow model of one request; updates state, returns the result.
  function automatic res_t allocate_or_free(logic cmd, logic [15:0] size,
                                            logic [19:0] faddr);
    res_t        r;
    int unsigned ent, c, limit, page, nxt, base, a;
    bit          found;
    r = '0;
    found = 0;
    if (cmd == CMD_ALLOC) begin
      for (int i = 0; i < NCLS; i++)
        if (!found && entry_bytes[i] >= size) begin
          c = i;
          found = 1;
        end
      if (!found) begin
        r.status = ST_TOO_LARGE;
      end else begin
        ent = entry_bytes[c];
        r.class_index = 4'(c);
        a = 0;
        if (free_head[c] != 0) begin
          a = free_head[c];
          free_head[c] = link_mem[a[19:2]];
        end else begin
          if (cursor[c] != 0) begin
            a = cursor[c];
          end else begin
            limit = (page_limit_reg < POOL_PG) ? page_limit_reg : POOL_PG;
            if (pages_taken >= limit) begin
              r.status = ST_NO_PAGES;
            end else begin
              page = pages_taken;
              pages_taken++;
              page_tag[page] = 4'(c);
              a = (page * PAGE_SZ + ((ent < 8) ? 8 : ent)) & 20'hFFFFF;
            end
          end
          if (r.status == ST_OK) begin
            base = a - (a % PAGE_SZ);
            nxt = a + ent;
            cursor[c] = (nxt + ent > base + PAGE_SZ) ? 20'd0 : nxt[19:0];
          end
        end
        if (r.status == ST_OK && live_objs[c] < COUNT_MAX) live_objs[c]++;
        r.entry_address = 20'(a);
        r.class_objects = live_objs[c];
      end
    end else begin
      page = faddr / PAGE_SZ;
      if (faddr == 0) r.status = ST_NULL;
      else if (faddr % PAGE_SZ == 0) r.status = ST_NOT_HANDL;
      else if (page >= pages_taken || page >= POOL_PG) r.status = ST_BAD_PAGE;
      else begin
        c = page_tag[page];
        if (c >= NCLS) c = 0;
        link_mem[faddr[19:2]] = free_head[c];
        free_head[c] = faddr;
        if (live_objs[c] > 0) live_objs[c]--;
        r.class_index = 4'(c);
        r.class_objects = live_objs[c];
      end
    end
    return r;
  endfunction

  task automatic send_request(logic cmd, logic [15:0] size, logic [19:0] faddr);
    res_t r;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = {4'b0, faddr, size};
    do @(posedge clk); while (!s_tready);
    r = allocate_or_free(cmd, size, faddr);
    pending_results.push_back(r);
    if (cmd == CMD_ALLOC && r.status == ST_OK) handed_out.push_back(r.entry_address);
    n_sent++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic write_page_limit(logic [8:0] value);
    wait (pending_results.size() == 0);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    page_limit_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic alloc(logic [15:0] size);
    send_request(CMD_ALLOC, size, 20'($urandom()));
  endtask

  task automatic free_at(logic [19:0] a);
    send_request(CMD_FREE, 16'($urandom()), a);
  endtask

  // Out-of-pages, too-large, null, page-aligned and never-taken-page frees.
  task automatic test_special_cases;
    write_page_limit(9'd1);
    alloc(16'd0);
    alloc(16'd4);
    alloc(16'd5);          // new class, no page left
    alloc(16'hFFFF);
    alloc(16'd1025);
    free_at(20'd0);
    free_at(20'd4096);
    free_at(20'hFFFFF);
    free_at(20'd8);
    alloc(16'd1);          // pops the entry just returned
    free_at(20'd13);       // odd address, pushed as is
    free_at(20'd13);       // double free
    alloc(16'd3);
    alloc(16'd2);
    write_page_limit(9'd0);
    alloc(16'd1024);
    write_page_limit(9'd511);
    for (int i = 1; i < NCLS; i++) alloc(16'(entry_bytes[i - 1] + 1));
  endtask

  task automatic random_request;
    int          pick, idx;
    logic [19:0] a;
    pick = $urandom_range(99);
    if (pick < 55 || handed_out.size() == 0) begin
      pick = $urandom_range(99);
      if (pick < 85) alloc(16'($urandom_range(128)));
      else if (pick < 96) alloc(16'($urandom_range(1024)));
      else alloc(16'($urandom()));
    end else if (pick < 85) begin
      idx = $urandom_range(handed_out.size() - 1);
      a = handed_out[idx];
      handed_out.delete(idx);
      free_at(a);
    end else if (pick < 91 && pages_taken > 0) begin
      a = 20'($urandom_range(pages_taken - 1) * PAGE_SZ + $urandom_range(1, PAGE_SZ - 1));
      free_at(a);
    end else begin
      pick = $urandom_range(3);
      if (pick == 0) free_at(20'd0);
      else if (pick == 1) free_at({8'($urandom_range(255)), 12'd0});
      else free_at(20'($urandom()));
    end
  endtask

  task automatic test_random_phase(int n, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    repeat (n) random_request();
  endtask

  // Receiver holds off long enough for the block to stop taking requests.
  task automatic test_backpressure;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 300;
    repeat (40) random_request();
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    res_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = '{entry_address: m_tdata[19:0], status: m_tdata[22:20],
              class_index: m_tdata[26:23], class_objects: m_tdata[44:27]};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %h", m_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display({"ERROR: result %0d exp addr=%h st=%0d cls=%0d objs=%0d",
                      " got addr=%h st=%0d cls=%0d objs=%0d"},
                     n_checked, want.entry_address, want.status, want.class_index,
                     want.class_objects, got.entry_address, got.status,
                     got.class_index, got.class_objects);
        end
      end
      n_checked++;
    end
  end

  // watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HOLD_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    page_limit_reg = 9'd256;
    pages_taken = 0;
    foreach (free_head[i]) begin
      free_head[i] = '0;
      cursor[i] = '0;
      live_objs[i] = '0;
    end
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_special_cases();
    write_page_limit(9'd256);
    test_random_phase(420, 0, 0);
    test_backpressure();
    test_random_phase(420, 84, 0);
    write_page_limit(9'd200);
    test_random_phase(420, 0, 84);
    write_page_limit(9'd256);
    test_random_phase(420, 13, 13);

    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    $display("Sent %0d requests, checked %0d results; %0d of %0d pages taken.",
             n_sent, n_checked, pages_taken, POOL_PG);
    $display("Covered all classes, stack pops, page carving, limits and bad frees.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/scsa_pkg.sv
rtl/scsa_front.sv
rtl/scsa_back.sv
rtl/size_class_slab_allocator.sv
tb/tb_top.sv
